@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_FRONT    = 3'd0,
        MODE_ADD_BACK     = 3'd1,
        MODE_REMOVE_FRONT = 3'd2,
        MODE_READ_FRONT   = 3'd3,
        MODE_READ_BACK    = 3'd4,
        MODE_READ_INDEX   = 3'd5,
        MODE_COUNT        = 3'd6
    } bdq_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } bdq_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } bdq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic load_data;  // capture store read data into the result register
    } bdq_dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read; // current request reads the store
    } bdq_dp_stat_t;

endpackage

@@ rtl/bdq_if.sv @@
interface bdq_req_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface bdq_rsp_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, status, data, count, input ready);
    modport sink   (input valid, status, data, count, output ready);
endinterface

@@ rtl/bdq_ram.sv @@
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/bdq_ctrl.sv @@
module bdq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  bdq_pkg::bdq_dp_stat_t dp_stat,
    output bdq_pkg::bdq_dp_cmd_t  dp_cmd
);
    import bdq_pkg::*;

    bdq_state_t state_reg;
    bdq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       load_result;

    // result register can take a new value this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && out_free && dp_stat.needs_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        dp_cmd           = '0;
        load_result      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = out_free;
                dp_cmd.accept = in_valid && out_free;
                load_result   = in_valid && out_free && !dp_stat.needs_read;
            end
            S_READ:
            begin
                dp_cmd.load_data = out_free;
                load_result      = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/bdq_datapath.sv @@
module bdq_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bdq_pkg::bdq_dp_cmd_t              dp_cmd,
    output bdq_pkg::bdq_dp_stat_t             dp_stat,
    input  logic [bdq_pkg::MODE_W-1:0]        mode,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    input  logic [bdq_pkg::POS_W-1:0]         position,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic signed [bdq_pkg::DATA_W-1:0] data,
    output logic [bdq_pkg::COUNT_W-1:0]       count
);
    import bdq_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = PW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int CNTX = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    bdq_mode_t           mode_c;
    logic [PW-1:0]       front_reg;
    logic [PW-1:0]       front_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                empty;
    logic                full;
    logic                pos_bad;
    logic [CMPW-1:0]     offset;
    logic [SW-1:0]       slot_sum;
    logic [SW-1:0]       slot_wrap;
    logic [PW-1:0]       slot;
    logic [PW-1:0]       front_dec;
    logic [PW-1:0]       front_inc;
    bdq_status_t         status_c;
    logic                push_front;
    logic                push_back;
    logic                pop;
    logic                needs_read;
    logic [CNTX-1:0]     count_x;
    logic [DATA_W-1:0]   ram_rdata;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [DATA_W-1:0]   rsp_data_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;

    assign mode_c  = bdq_mode_t'(mode);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_C);
    assign pos_bad = (CMPW'(position) >= CMPW'(count_reg));

    // offset from the front for the slot being touched
    always_comb
    begin
        case (mode_c)
            MODE_ADD_BACK:   offset = CMPW'(count_reg);
            MODE_READ_BACK:  offset = CMPW'(count_reg - CW'(1));
            MODE_READ_INDEX: offset = CMPW'(position);
            default:         offset = '0;
        endcase
    end

    // ring slot: front + offset, one wrap at most
    assign slot_sum  = SW'(front_reg) + SW'(offset[PW-1:0]);
    assign slot_wrap = slot_sum - DEPTH_S;
    assign slot      = (slot_sum >= DEPTH_S) ? slot_wrap[PW-1:0] : slot_sum[PW-1:0];

    assign front_dec = (front_reg == '0) ? LAST_P : front_reg - PW'(1);
    assign front_inc = (front_reg == LAST_P) ? '0 : front_reg + PW'(1);

    always_comb
    begin
        status_c   = ST_OK;
        push_front = 1'b0;
        push_back  = 1'b0;
        pop        = 1'b0;
        needs_read = 1'b0;
        unique case (mode_c) inside
            MODE_ADD_FRONT, MODE_ADD_BACK:
            begin
                if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    push_front = (mode_c == MODE_ADD_FRONT);
                    push_back  = (mode_c == MODE_ADD_BACK);
                end
            end
            MODE_REMOVE_FRONT:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            MODE_READ_FRONT, MODE_READ_BACK:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    needs_read = 1'b1;
                end
            end
            MODE_READ_INDEX:
            begin
                if (empty)
                begin
                    status_c = ST_EMPTY;
                end
                else if (pos_bad)
                begin
                    status_c = ST_BADPOS;
                end
                else
                begin
                    needs_read = 1'b1;
                end
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    assign dp_stat.needs_read = needs_read;

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + CW'(1);
        end
        else if (push_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop)
        begin
            front_next = front_inc;
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (dp_cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (dp_cmd.accept && (push_front || push_back)),
        .waddr (push_front ? front_dec : slot),
        .wdata (value),
        .re    (dp_cmd.accept && needs_read),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign count_x = CNTX'(count_next);

    // result register; on reads the data is loaded from the store read port in the read state
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            rsp_status_reg <= status_c;
            rsp_count_reg  <= count_x[COUNT_W-1:0];
            if (!needs_read)
            begin
                rsp_data_reg <= '0;
            end
        end
        if (dp_cmd.load_data)
        begin
            rsp_data_reg <= ram_rdata;
        end
    end

    assign status = rsp_status_reg;
    assign data   = $signed(rsp_data_reg);
    assign count  = rsp_count_reg;

endmodule

@@ rtl/bounded_deque_with_index_read_top.sv @@
// Results: adds, remove, count and reads that report an error status give their result
//   in the cycle after the request is taken; successful reads of the front, back or an
//   index pass through the registered store read port and then the result register.
// Throughput: 1 request per cycle while results are taken, but none during a store read;
//   a new request is taken while the previous result is taken in the same cycle.
// Reset: front pointer, entry count, state and result valid clear at once;
//   store contents stay undefined and need no clearing pass.
module bounded_deque_with_index_read_top #(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    bdq_req_if.sink     req,
    bdq_rsp_if.source   rsp
);
    import bdq_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

    bdq_dp_cmd_t  dp_cmd;
    bdq_dp_stat_t dp_stat;

    // Controller: owns the handshakes and sequences the store read.
    // It takes a request only when the result register is free (or being drained),
    // and holds off new requests while the store read is in progress (read state).
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // Datapath: ring store with front pointer and count, status decode,
    // slot address math (one compare-and-subtract wrap), result register.
    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat),
        .mode     (req.mode),
        .value    (req.value),
        .position (req.position),
        .status   (rsp.status),
        .data     (rsp.data),
        .count    (rsp.count)
    );

    // A full status can only be reported with the list holding DEPTH entries.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL) |-> (rsp.count == FULL_CNT))
        else $error("full status with count below capacity");

    // Empty status means zero entries and no data.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.count == '0 && rsp.data == '0))
        else $error("empty status with entries held or data set");

    // Requests that do not read the store produce their result the next cycle.
    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode != MODE_READ_FRONT
         && req.mode != MODE_READ_BACK && req.mode != MODE_READ_INDEX) |=> rsp.valid)
        else $error("non-read request did not produce a result");

    // Data is only nonzero on a successful read result.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.data == '0))
        else $error("data set on an error status");

endmodule
